// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MDV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Expression must never be true outside reset.
`define MDV_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");

`endif

// ----- rtl/mdv_pkg.sv -----
// Shared widths, constants and the queued item type.
package mdv_pkg;
  localparam int HALF_W         = 32;
  localparam int WORD_W         = 64;
  localparam int PROD_W         = WORD_W + HALF_W;
  localparam int MDV_FIFO_DEPTH = 4;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [HALF_W-1:0] divisor;
    logic              ovf;
    logic              dbz;
  } item_t;
endpackage

// ----- rtl/mdv_front.sv -----
// Front end: accepts items, forms the 96-bit product and classifies them.
module mdv_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mdv_pkg::WORD_W-1:0] in_multiplicand,
  input  logic [mdv_pkg::HALF_W-1:0] in_multiplier,
  input  logic [mdv_pkg::HALF_W-1:0] in_divisor,
  output logic                       push_valid,
  input  logic                       push_full,
  output mdv_pkg::item_t             push_item
);
  import mdv_pkg::*;

  logic              v1_r, v2_r, v3_r;
  logic              rdy1, rdy2, rdy3;
  logic [WORD_W-1:0] a_r;
  logic [HALF_W-1:0] b_r, c1_r, c2_r;
  logic [WORD_W-1:0] pp_lo_r, pp_hi_r;
  logic [WORD_W-1:0] prod_hi;
  item_t             item_nxt, item_r;

  assign rdy3     = !v3_r || !push_full;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // high part of product: bits 95..32
  assign prod_hi = pp_hi_r + {{HALF_W{1'b0}}, pp_lo_r[WORD_W-1:HALF_W]};

  always_comb begin
    item_nxt.prod    = {prod_hi, pp_lo_r[HALF_W-1:0]};
    item_nxt.divisor = c2_r;
    item_nxt.dbz     = (c2_r == '0);
    // quotient exceeds 64 bits when the top 32 bits alone reach the divisor
    item_nxt.ovf     = (prod_hi[WORD_W-1:HALF_W] >= c2_r) && (c2_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
    if (rdy1 && in_valid) begin
      a_r  <= in_multiplicand;
      b_r  <= in_multiplier;
      c1_r <= in_divisor;
    end
    if (rdy2 && v1_r) begin
      pp_lo_r <= a_r[HALF_W-1:0] * b_r;
      pp_hi_r <= a_r[WORD_W-1:HALF_W] * b_r;
      c2_r    <= c1_r;
    end
    if (rdy3 && v2_r) item_r <= item_nxt;
  end

  assign push_valid = v3_r;
  assign push_item  = item_r;
endmodule

// ----- rtl/mdv_fifo.sv -----
// Short item queue between the front end and the divider.
`include "assert_macros.svh"
module mdv_fifo #(
  parameter int DEPTH = mdv_pkg::MDV_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           full,
  input  mdv_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mdv_pkg::item_t pop_item
);
  import mdv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign full      = (cnt_r == FULLC);
  assign pop_valid = (cnt_r != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == LAST) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == LAST) ? '0 : rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem[wr_r] <= push_item;
  end

  `MDV_ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > FULLC)
endmodule

// ----- rtl/mdv_div.sv -----
// Back end: 64-stage restoring divider with an output register.
module mdv_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  mdv_pkg::item_t             pop_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mdv_pkg::WORD_W-1:0] out_quotient,
  output logic                       out_overflow,
  output logic                       out_divide_by_zero
);
  import mdv_pkg::*;

  localparam int STEPS = WORD_W;

  logic              v_r    [STEPS];
  logic [HALF_W-1:0] rem_r  [STEPS];
  logic [WORD_W-1:0] work_r [STEPS];
  logic [HALF_W-1:0] div_r  [STEPS];
  logic              ovf_r  [STEPS];
  logic              dbz_r  [STEPS];
  logic              rdy    [STEPS];
  logic              out_rdy;
  logic              vo_r;
  logic [WORD_W-1:0] q_r;
  logic              ovfo_r, dbzo_r;

  assign out_rdy   = !vo_r || !out_stall;
  assign pop_ready = rdy[0];

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    logic              v_in, ovf_in, dbz_in, ge, rdy_nx;
    logic [HALF_W-1:0] rem_in, div_in;
    logic [WORD_W-1:0] work_in;
    logic [HALF_W:0]   trial, diff;

    if (g == 0) begin : g_first
      assign v_in    = pop_valid;
      assign rem_in  = pop_item.prod[PROD_W-1:WORD_W];
      assign work_in = pop_item.prod[WORD_W-1:0];
      assign div_in  = pop_item.divisor;
      assign ovf_in  = pop_item.ovf;
      assign dbz_in  = pop_item.dbz;
    end else begin : g_next
      assign v_in    = v_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign work_in = work_r[g-1];
      assign div_in  = div_r[g-1];
      assign ovf_in  = ovf_r[g-1];
      assign dbz_in  = dbz_r[g-1];
    end

    if (g == STEPS - 1) begin : g_last
      assign rdy_nx = out_rdy;
    end else begin : g_mid
      assign rdy_nx = rdy[g+1];
    end

    assign rdy[g] = !v_r[g] || rdy_nx;
    // shift one dividend bit into the partial remainder
    assign trial  = {rem_in, work_in[WORD_W-1]};
    assign diff   = trial - {1'b0, div_in};
    assign ge     = (trial >= {1'b0, div_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_r[g] <= v_in;
      end
      if (rdy[g] && v_in) begin
        rem_r[g]  <= ge ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
        work_r[g] <= {work_in[WORD_W-2:0], ge};
        div_r[g]  <= div_in;
        ovf_r[g]  <= ovf_in;
        dbz_r[g]  <= dbz_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (out_rdy) begin
      vo_r <= v_r[STEPS-1];
    end
    if (out_rdy && v_r[STEPS-1]) begin
      priority if (dbz_r[STEPS-1]) begin
        q_r    <= '0;
        ovfo_r <= 1'b0;
        dbzo_r <= 1'b1;
      end else if (ovf_r[STEPS-1]) begin
        q_r    <= '1;
        ovfo_r <= 1'b1;
        dbzo_r <= 1'b0;
      end else begin
        q_r    <= work_r[STEPS-1];
        ovfo_r <= 1'b0;
        dbzo_r <= 1'b0;
      end
    end
  end

  assign out_valid          = vo_r;
  assign out_quotient       = q_r;
  assign out_overflow       = ovfo_r;
  assign out_divide_by_zero = dbzo_r;
endmodule

// ----- rtl/mul_div_64x32_by_32_core.sv -----
// Top level: floor(multiplicand * multiplier / divisor) with 96-bit product.
// One item is accepted per cycle when neither side stalls; each accepted item
// passes through three front-end stages forming the 96-bit product, one queue
// slot, 64 restoring-divide stages of one quotient bit each, and the output
// register. A queue of FIFO_DEPTH items sits between product and divider. A
// zero divisor gives quotient 0 with divide_by_zero set; a quotient wider
// than 64 bits gives all ones with overflow set.
`include "assert_macros.svh"
module mul_div_64x32_by_32_core #(
  parameter int FIFO_DEPTH = mdv_pkg::MDV_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mdv_pkg::WORD_W-1:0] in_multiplicand,
  input  logic [mdv_pkg::HALF_W-1:0] in_multiplier,
  input  logic [mdv_pkg::HALF_W-1:0] in_divisor,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mdv_pkg::WORD_W-1:0] out_quotient,
  output logic                       out_overflow,
  output logic                       out_divide_by_zero
);
  import mdv_pkg::*;

  logic  push_valid, push_full, pop_valid, pop_ready;
  item_t push_item, pop_item;

  mdv_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_multiplicand, .in_multiplier,
    .in_divisor, .push_valid, .push_full, .push_item
  );

  mdv_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst_n, .push_valid, .full(push_full), .push_item,
    .pop_valid, .pop_ready, .pop_item
  );

  mdv_div u_div (
    .clk, .rst_n, .pop_valid, .pop_ready, .pop_item, .out_valid, .out_stall,
    .out_quotient, .out_overflow, .out_divide_by_zero
  );

  `MDV_ASSERT_IMPLY(a_dbz_zero, clk, rst_n, out_valid && out_divide_by_zero, out_quotient == '0 && !out_overflow)
  `MDV_ASSERT_IMPLY(a_ovf_sat, clk, rst_n, out_valid && out_overflow, out_quotient == '1)
  `MDV_ASSERT_NEVER(a_flags_excl, clk, rst_n, out_valid && out_overflow && out_divide_by_zero)
endmodule

// ----- verif/mul_div_64x32_by_32_checker.sv -----
// Checker: predicts each quotient from accepted items and compares results.
`timescale 1ns / 1ps
module mul_div_64x32_by_32_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [mdv_pkg::WORD_W-1:0] in_multiplicand,
  input  logic [mdv_pkg::HALF_W-1:0] in_multiplier,
  input  logic [mdv_pkg::HALF_W-1:0] in_divisor,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [mdv_pkg::WORD_W-1:0] out_quotient,
  input  logic                       out_overflow,
  input  logic                       out_divide_by_zero,
  output int                         fail_count,
  output int                         pending
);
  typedef struct packed {
    logic [63:0] quotient;
    logic        overflow;
    logic        divide_by_zero;
  } scaled_t;

  scaled_t quotient_q[$];

  function automatic scaled_t scale_divide(logic [63:0] a, logic [31:0] b, logic [31:0] c);
    logic [95:0]  prod;
    logic [127:0] q;
    scaled_t      r;
    r = '0;
    if (c == 0) begin
      r.divide_by_zero = 1'b1;
    end else begin
      prod = {32'd0, a} * {64'd0, b};
      q = {32'd0, prod} / {96'd0, c};
      if (q[127:64] != 0) begin
        r.quotient = '1;
        r.overflow = 1'b1;
      end else begin
        r.quotient = q[63:0];
      end
    end
    return r;
  endfunction

  assign pending = quotient_q.size();

  always @(posedge clk) begin
    scaled_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        quotient_q.push_back(scale_divide(in_multiplicand, in_multiplier, in_divisor));
      if (out_valid && !out_stall) begin
        if (quotient_q.size() == 0) begin
          $display("%0t: unexpected result q=%h ovf=%b dbz=%b", $time, out_quotient,
                   out_overflow, out_divide_by_zero);
          fail_count <= fail_count + 1;
        end else begin
          want = quotient_q.pop_front();
          if (want != {out_quotient, out_overflow, out_divide_by_zero}) begin
            $display("%0t: expected q=%h ovf=%b dbz=%b, actual q=%h ovf=%b dbz=%b", $time,
                     want.quotient, want.overflow, want.divide_by_zero, out_quotient,
                     out_overflow, out_divide_by_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- verif/tb_mul_div_64x32_by_32_core.sv -----
// Testbench top: drives directed and random items and reports the verdict.
`timescale 1ns / 1ps
module tb_mul_div_64x32_by_32_core;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_multiplicand;
  logic [31:0] in_multiplier;
  logic [31:0] in_divisor;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_quotient;
  logic        out_overflow;
  logic        out_divide_by_zero;
  int          fail_count;
  int          pending;
  int          cycles;
  logic [127:0] directed[$];

  mul_div_64x32_by_32_core dut (.*);

  mul_div_64x32_by_32_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls in runs of random length
  initial begin
    int run;
    out_stall = 0;
    forever begin
      run = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      out_stall <= ($urandom_range(0, 2) == 0);
      repeat (run + 1) @(posedge clk);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("tb_mul_div_64x32_by_32_core NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_wide();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = '1;
      2: v = 0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_half();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 6))
      0: v = v >> $urandom_range(0, 31);
      1: v = '1;
      2: v = 0;
      3: v = 1;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(logic [63:0] a, logic [31:0] b, logic [31:0] c);
    in_valid <= 1'b1;
    in_multiplicand <= a;
    in_multiplier <= b;
    in_divisor <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  initial begin
    logic [127:0] d;
    int burst;
    int sent;
    rst_n = 0;
    in_valid = 0;
    in_multiplicand = 0;
    in_multiplier = 0;
    in_divisor = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // extremes, zero divisor, overflow boundary
    directed = '{{64'd0, 32'd0, 32'd0}, {64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0},
                 {64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                 {64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE},
                 {64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd1},
                 {64'hFFFF_FFFF_FFFF_FFFF, 32'd2, 32'd1},
                 {64'h8000_0000_0000_0000, 32'd2, 32'd1},
                 {64'h7FFF_FFFF_FFFF_FFFF, 32'd2, 32'd1},
                 {64'd0, 32'hFFFF_FFFF, 32'd1}, {64'd1, 32'd1, 32'hFFFF_FFFF},
                 {64'h0000_0001_0000_0000, 32'h8000_0000, 32'h4000_0000},
                 {64'd12345678901, 32'd1000000000, 32'd3}, {64'd7, 32'd3, 32'd2}};
    foreach (directed[i]) begin
      d = directed[i];
      send_item(d[127:64], d[63:32], d[31:0]);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    sent = 0;
    while (sent < 1750) begin
      burst = $urandom_range(0, 4) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 16);
      repeat (burst) begin
        send_item(rand_wide(), rand_half(), rand_half());
        sent++;
      end
      if (sent > 900 && sent < 920) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        idle_gap();
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("tb_mul_div_64x32_by_32_core OK");
    else
      $display("tb_mul_div_64x32_by_32_core NOT OK");
    $finish;
  end
endmodule
